>>> sv/mdh_pkg.sv
`timescale 1ns / 1ps

package mdh_pkg;

    // CORDIC datapath, Q2.29 with headroom bits
    localparam int CORDIC_W      = 34;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;

    localparam int ANGLE_W = 16;
    localparam int TRIG_W  = 16;
    localparam int LEN_W   = 32;

    localparam logic signed [CORDIC_W-1:0] INV_GAIN = CORDIC_W'(326016437);
    localparam logic signed [CORDIC_W-1:0] PI_Q29   = CORDIC_W'(1686629713);
    localparam logic signed [CORDIC_W-1:0] HALF_PI  = CORDIC_W'(843314857);

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
        logic                       flip;
    } lane_t;

    // atan(2^-i) in Q2.29, rounded to nearest
    function automatic logic signed [CORDIC_W-1:0] atan_q29(input int idx);
        logic signed [CORDIC_W-1:0] r;
        case (idx)
            0:       r = CORDIC_W'(421657428);
            1:       r = CORDIC_W'(248918915);
            2:       r = CORDIC_W'(131521918);
            3:       r = CORDIC_W'(66762579);
            4:       r = CORDIC_W'(33510843);
            5:       r = CORDIC_W'(16771758);
            6:       r = CORDIC_W'(8387925);
            7:       r = CORDIC_W'(4194219);
            8:       r = CORDIC_W'(2097141);
            9:       r = CORDIC_W'(1048575);
            10:      r = CORDIC_W'(524288);
            11:      r = CORDIC_W'(262144);
            12:      r = CORDIC_W'(131072);
            13:      r = CORDIC_W'(65536);
            14:      r = CORDIC_W'(32768);
            15:      r = CORDIC_W'(16384);
            16:      r = CORDIC_W'(8192);
            17:      r = CORDIC_W'(4096);
            18:      r = CORDIC_W'(2048);
            19:      r = CORDIC_W'(1024);
            20:      r = CORDIC_W'(512);
            21:      r = CORDIC_W'(256);
            22:      r = CORDIC_W'(128);
            23:      r = CORDIC_W'(64);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/mdh_link_transform_unit.sv
`timescale 1ns / 1ps

// Channel   | Dir | Signals                    | Payload
// ----------+-----+----------------------------+----------------------------------
// s_ (in)   | in  | s_tvalid s_tready s_tdata  | 96 bit: a, alpha, d, theta
// m_ (out)  | out | m_tvalid m_tready m_tdata  | 224 bit: eleven transform entries
//
// One request accepted per cycle unless a stalled output has backed the pipe
// up; one result per request, in order. Registers in order: fold stage, the
// CORDIC iteration stages, trig rounding, multiply, product rounding/saturation.
// aresetn is synchronous, active low, and clears the valid bits only.
// Each stage has its own valid bit and loads when empty or when the next
// stage moves, so a stalled output lets bubbles upstream fill up.
module mdh_link_transform_unit #(
    parameter int CORDIC_STAGES = mdh_pkg::CORDIC_STAGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] link_length, [47:32] link_twist, [79:48] link_offset,
    // [95:80] joint_angle
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] r00_cos_theta, [31:16] r01_neg_sin_theta, [63:32] r03_length,
    // [79:64] r10_st_ca, [95:80] r11_ct_ca, [111:96] r12_neg_sa,
    // [143:112] r13_neg_d_sa, [159:144] r20_st_sa, [175:160] r21_ct_sa,
    // [191:176] r22_cos_alpha, [223:192] r23_d_ca
    output logic [223:0] m_tdata
);

    localparam int W  = mdh_pkg::CORDIC_W;
    localparam int TW = mdh_pkg::TRIG_W;
    localparam int LW = mdh_pkg::LEN_W;
    localparam int PW = 2 * TW;        // trig product
    localparam int QW = LW + TW;       // length product

    localparam logic signed [W-1:0]  TRIG_RND = W'(16384);
    localparam logic signed [W-1:0]  TRIG_MAX = W'(16384);
    localparam logic signed [W-1:0]  TRIG_MIN = -W'(16384);
    localparam logic signed [PW:0]   PROD_RND = (PW+1)'(8192);
    localparam logic signed [QW:0]   LEN_RND  = (QW+1)'(8192);
    localparam logic signed [QW:0]   LEN_MAX  = (QW+1)'(64'sd2147483647);
    localparam logic signed [QW:0]   LEN_MIN  = -(QW+1)'(64'sd2147483648);

    // Q2.29 to Q1.14: round half up, clamp to +-1
    function automatic logic signed [TW-1:0] round_trig(input logic signed [W-1:0] v);
        logic signed [W-1:0] t;
        t = (v + TRIG_RND) >>> 15;
        if (t > TRIG_MAX) begin
            t = TRIG_MAX;
        end else if (t < TRIG_MIN) begin
            t = TRIG_MIN;
        end
        return t[TW-1:0];
    endfunction

    function automatic logic signed [TW-1:0] round_prod(input logic signed [PW-1:0] p);
        logic signed [PW:0] t;
        t = ((PW+1)'(p) + PROD_RND) >>> 14;
        return t[TW-1:0];
    endfunction

    function automatic logic signed [LW-1:0] round_len(input logic signed [QW-1:0] p);
        logic signed [QW:0] t;
        t = ((QW+1)'(p) + LEN_RND) >>> 14;
        if (t > LEN_MAX) begin
            t = LEN_MAX;
        end else if (t < LEN_MIN) begin
            t = LEN_MIN;
        end
        return t[LW-1:0];
    endfunction

    // ---- CORDIC (fold + iterations), a and d ride along ----
    logic           cor_valid;
    logic           cor_ready;
    mdh_pkg::lane_t cor_theta;
    mdh_pkg::lane_t cor_alpha;
    logic [2*LW-1:0] cor_pass;

    mdh_cordic #(
        .STAGES (CORDIC_STAGES),
        .PASS_W (2 * LW)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_theta  (s_tdata[95:80]),
        .in_alpha  (s_tdata[47:32]),
        .in_pass   ({s_tdata[79:48], s_tdata[31:0]}),
        .out_valid (cor_valid),
        .out_ready (cor_ready),
        .out_theta (cor_theta),
        .out_alpha (cor_alpha),
        .out_pass  (cor_pass)
    );

    // ---- stage R: sign fix and trig rounding ----
    logic                 r_valid_reg;
    logic                 r_ready;
    logic signed [TW-1:0] r_ct_reg, r_st_reg, r_ca_reg, r_sa_reg, r_nsa_reg;
    logic signed [LW-1:0] r_a_reg, r_d_reg;
    logic signed [TW-1:0] ct_next, st_next, ca_next, sa_next;

    always_comb begin
        ct_next = round_trig(cor_theta.flip ? -cor_theta.x : cor_theta.x);
        st_next = round_trig(cor_theta.flip ? -cor_theta.y : cor_theta.y);
        ca_next = round_trig(cor_alpha.flip ? -cor_alpha.x : cor_alpha.x);
        sa_next = round_trig(cor_alpha.flip ? -cor_alpha.y : cor_alpha.y);
    end

    // ---- stage M: products ----
    logic                 m_valid_reg;
    logic                 m_ready;
    logic signed [TW-1:0] m_ct_reg, m_nst_reg, m_nsa_reg, m_ca_reg;
    logic signed [LW-1:0] m_a_reg;
    logic signed [PW-1:0] m_st_ca_reg, m_ct_ca_reg, m_st_sa_reg, m_ct_sa_reg;
    logic signed [QW-1:0] m_d_nsa_reg, m_d_ca_reg;

    // ---- stage O: output register ----
    logic         o_valid_reg;
    logic         o_ready;
    logic [223:0] o_data_reg;

    assign o_ready   = !o_valid_reg || m_tready;
    assign m_ready   = !m_valid_reg || o_ready;
    assign r_ready   = !r_valid_reg || m_ready;
    assign cor_ready = r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (r_ready) begin
                r_valid_reg <= cor_valid;
            end
            if (m_ready) begin
                m_valid_reg <= r_valid_reg;
            end
            if (o_ready) begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r_ready) begin
            r_ct_reg  <= ct_next;
            r_st_reg  <= st_next;
            r_ca_reg  <= ca_next;
            r_sa_reg  <= sa_next;
            r_nsa_reg <= -sa_next;
            r_a_reg   <= cor_pass[LW-1:0];
            r_d_reg   <= cor_pass[2*LW-1:LW];
        end
        if (m_ready) begin
            m_ct_reg    <= r_ct_reg;
            m_nst_reg   <= -r_st_reg;
            m_nsa_reg   <= r_nsa_reg;
            m_ca_reg    <= r_ca_reg;
            m_a_reg     <= r_a_reg;
            m_st_ca_reg <= PW'(r_st_reg) * PW'(r_ca_reg);
            m_ct_ca_reg <= PW'(r_ct_reg) * PW'(r_ca_reg);
            m_st_sa_reg <= PW'(r_st_reg) * PW'(r_sa_reg);
            m_ct_sa_reg <= PW'(r_ct_reg) * PW'(r_sa_reg);
            m_d_nsa_reg <= QW'(r_d_reg) * QW'(r_nsa_reg);
            m_d_ca_reg  <= QW'(r_d_reg) * QW'(r_ca_reg);
        end
        if (o_ready) begin
            o_data_reg <= {round_len(m_d_ca_reg),
                           m_ca_reg,
                           round_prod(m_ct_sa_reg),
                           round_prod(m_st_sa_reg),
                           round_len(m_d_nsa_reg),
                           m_nsa_reg,
                           round_prod(m_ct_ca_reg),
                           round_prod(m_st_ca_reg),
                           m_a_reg,
                           m_nst_reg,
                           m_ct_reg};
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

endmodule

>>> sv/mdh_cordic.sv
`timescale 1ns / 1ps

// Two-lane pipelined rotation CORDIC (theta and alpha) with a side payload.
// Stage 0 folds the angle into +-pi/2; stages 1..NS iterate.
module mdh_cordic #(
    parameter int STAGES = mdh_pkg::CORDIC_STAGES,
    parameter int PASS_W = 64
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [mdh_pkg::ANGLE_W-1:0]      in_theta,
    input  logic signed [mdh_pkg::ANGLE_W-1:0]      in_alpha,
    input  logic        [PASS_W-1:0]                in_pass,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output mdh_pkg::lane_t                          out_theta,
    output mdh_pkg::lane_t                          out_alpha,
    output logic        [PASS_W-1:0]                out_pass
);

    localparam int NS = (STAGES > mdh_pkg::ATAN_LEN) ? mdh_pkg::ATAN_LEN : STAGES;
    localparam int W  = mdh_pkg::CORDIC_W;

    logic           v_reg    [0:NS];
    mdh_pkg::lane_t lt_reg   [0:NS];
    mdh_pkg::lane_t la_reg   [0:NS];
    logic [PASS_W-1:0] pass_reg [0:NS];
    logic           rdy      [0:NS+1];

    function automatic mdh_pkg::lane_t prerot(input logic signed [mdh_pkg::ANGLE_W-1:0] ang);
        mdh_pkg::lane_t l;
        logic signed [W-1:0] z;
        z      = W'(ang) <<< 16;
        l.x    = mdh_pkg::INV_GAIN;
        l.y    = '0;
        l.flip = 1'b0;
        if (z > mdh_pkg::HALF_PI) begin
            l.z    = z - mdh_pkg::PI_Q29;
            l.flip = 1'b1;
        end else if (z < -mdh_pkg::HALF_PI) begin
            l.z    = z + mdh_pkg::PI_Q29;
            l.flip = 1'b1;
        end else begin
            l.z = z;
        end
        return l;
    endfunction

    function automatic mdh_pkg::lane_t rot_step(input mdh_pkg::lane_t l, input int sh,
                                                input logic signed [W-1:0] atn);
        mdh_pkg::lane_t r;
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        dx     = l.y >>> sh;
        dy     = l.x >>> sh;
        r.flip = l.flip;
        if (!l.z[W-1]) begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atn;
        end else begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atn;
        end
        return r;
    endfunction

    assign rdy[NS+1] = out_ready;
    assign in_ready  = rdy[0];

    for (genvar k = 0; k <= NS; k++) begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    // fold stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (rdy[0]) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            lt_reg[0]   <= prerot(in_theta);
            la_reg[0]   <= prerot(in_alpha);
            pass_reg[0] <= in_pass;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        localparam logic signed [W-1:0] ATN = mdh_pkg::atan_q29(i);
        mdh_pkg::lane_t lt_next;
        mdh_pkg::lane_t la_next;

        always_comb begin
            lt_next = rot_step(lt_reg[i], i, ATN);
            la_next = rot_step(la_reg[i], i, ATN);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i+1] <= 1'b0;
            end else if (rdy[i+1]) begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i+1]) begin
                lt_reg[i+1]   <= lt_next;
                la_reg[i+1]   <= la_next;
                pass_reg[i+1] <= pass_reg[i];
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign out_theta = lt_reg[NS];
    assign out_alpha = la_reg[NS];
    assign out_pass  = pass_reg[NS];

endmodule

>>> sv/mdh_checker.sv
`timescale 1ns / 1ps

module mdh_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // empty output register means every stage can move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output register empty");

    // cos theta and cos alpha stay within +-1.0 in Q1.14
    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384) &&
                     ($signed(m_tdata[15:0]) >= -16'sd16384) &&
                     ($signed(m_tdata[191:176]) <= 16'sd16384) &&
                     ($signed(m_tdata[191:176]) >= -16'sd16384))
        else $error("trig entry out of range");

endmodule

bind mdh_link_transform_unit mdh_checker u_mdh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/mdh_link_xform_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the link transform unit, predicts each result from
// the accepted request and compares it field by field, oldest first.
module mdh_link_xform_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    // [31:0] link_length, [47:32] link_twist, [79:48] link_offset,
    // [95:80] joint_angle
    input  logic [95:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] r00_cos_theta, [31:16] r01_neg_sin_theta, [63:32] r03_length,
    // [79:64] r10_st_ca, [95:80] r11_ct_ca, [111:96] r12_neg_sa,
    // [143:112] r13_neg_d_sa, [159:144] r20_st_sa, [175:160] r21_ct_sa,
    // [191:176] r22_cos_alpha, [223:192] r23_d_ca
    input  logic [223:0] m_tdata,
    output int           mismatches,
    output int           outstanding
);

    localparam int ANGLE_W = mdh_pkg::ANGLE_W;
    localparam int TRIG_W  = mdh_pkg::TRIG_W;
    localparam int LEN_W   = mdh_pkg::LEN_W;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] joint_angle;
        logic signed [LEN_W-1:0]   link_offset;
        logic signed [ANGLE_W-1:0] link_twist;
        logic signed [LEN_W-1:0]   link_length;
    } link_req_t;

    // first member sits in the top bits
    typedef struct packed {
        logic signed [LEN_W-1:0]  r23_d_ca;
        logic signed [TRIG_W-1:0] r22_cos_alpha;
        logic signed [TRIG_W-1:0] r21_ct_sa;
        logic signed [TRIG_W-1:0] r20_st_sa;
        logic signed [LEN_W-1:0]  r13_neg_d_sa;
        logic signed [TRIG_W-1:0] r12_neg_sa;
        logic signed [TRIG_W-1:0] r11_ct_ca;
        logic signed [TRIG_W-1:0] r10_st_ca;
        logic signed [LEN_W-1:0]  r03_length;
        logic signed [TRIG_W-1:0] r01_neg_sin_theta;
        logic signed [TRIG_W-1:0] r00_cos_theta;
    } link_xform_t;

    localparam longint UNIT_GAIN_Q29 = 64'sd326016437;
    localparam longint PI_RAD_Q29    = 64'sd1686629713;
    localparam longint PI_HALF_Q29   = 64'sd843314857;
    localparam int     ROT_STEPS     = (mdh_pkg::CORDIC_STAGES > mdh_pkg::ATAN_LEN) ?
                                       mdh_pkg::ATAN_LEN : mdh_pkg::CORDIC_STAGES;

    // atan(2^-i), Q2.29
    longint arctan_q29 [0:23] = '{
        421657428, 248918915, 131521918, 66762579,
        33510843, 16771758, 8387925, 4194219,
        2097141, 1048575, 524288, 262144,
        131072, 65536, 32768, 16384,
        8192, 4096, 2048, 1024,
        512, 256, 128, 64
    };

    link_xform_t pending_xforms [$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // cos/sin of a Q2.13 angle, both in Q1.14
    function automatic void rotate_angle(input logic signed [ANGLE_W-1:0] angle,
                                         output longint cos_q14, output longint sin_q14);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     negate;
        z      = longint'(angle) * 65536;
        x      = UNIT_GAIN_Q29;
        y      = 0;
        negate = 1'b0;
        if (z > PI_HALF_Q29) begin
            z      = z - PI_RAD_Q29;
            negate = 1'b1;
        end else if (z < -PI_HALF_Q29) begin
            z      = z + PI_RAD_Q29;
            negate = 1'b1;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_q29[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_q29[i];
            end
        end
        if (negate) begin
            x = -x;
            y = -y;
        end
        cos_q14 = clip((x + 16384) >>> 15, -16384, 16384);
        sin_q14 = clip((y + 16384) >>> 15, -16384, 16384);
    endfunction

    function automatic longint trig_product(input longint p, input longint q);
        return clip((p * q + 8192) >>> 14, -16384, 16384);
    endfunction

    function automatic longint length_product(input longint len, input longint trig);
        return clip((len * trig + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647);
    endfunction

    function automatic link_xform_t predict_link_xform(input link_req_t req);
        link_xform_t t;
        longint      ct;
        longint      st;
        longint      ca;
        longint      sa;
        rotate_angle(req.joint_angle, ct, st);
        rotate_angle(req.link_twist, ca, sa);
        t.r00_cos_theta     = TRIG_W'(ct);
        t.r01_neg_sin_theta = TRIG_W'(-st);
        t.r03_length        = req.link_length;
        t.r10_st_ca         = TRIG_W'(trig_product(st, ca));
        t.r11_ct_ca         = TRIG_W'(trig_product(ct, ca));
        t.r12_neg_sa        = TRIG_W'(-sa);
        t.r13_neg_d_sa      = LEN_W'(length_product(longint'(req.link_offset), -sa));
        t.r20_st_sa         = TRIG_W'(trig_product(st, sa));
        t.r21_ct_sa         = TRIG_W'(trig_product(ct, sa));
        t.r22_cos_alpha     = TRIG_W'(ca);
        t.r23_d_ca          = LEN_W'(length_product(longint'(req.link_offset), ca));
        return t;
    endfunction

    task automatic check_entry(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, $signed(want),
                     $signed(got));
        end
    endtask

    always @(posedge aclk) begin : watch
        link_xform_t got;
        link_xform_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_xforms.push_back(predict_link_xform(link_req_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_xforms.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding, got %h", $time,
                             m_tdata);
                end else begin
                    want = pending_xforms.pop_front();
                    check_entry("r00_cos_theta", want.r00_cos_theta, got.r00_cos_theta);
                    check_entry("r01_neg_sin_theta", want.r01_neg_sin_theta,
                                got.r01_neg_sin_theta);
                    check_entry("r03_length", want.r03_length, got.r03_length);
                    check_entry("r10_st_ca", want.r10_st_ca, got.r10_st_ca);
                    check_entry("r11_ct_ca", want.r11_ct_ca, got.r11_ct_ca);
                    check_entry("r12_neg_sa", want.r12_neg_sa, got.r12_neg_sa);
                    check_entry("r13_neg_d_sa", want.r13_neg_d_sa, got.r13_neg_d_sa);
                    check_entry("r20_st_sa", want.r20_st_sa, got.r20_st_sa);
                    check_entry("r21_ct_sa", want.r21_ct_sa, got.r21_ct_sa);
                    check_entry("r22_cos_alpha", want.r22_cos_alpha, got.r22_cos_alpha);
                    check_entry("r23_d_ca", want.r23_d_ca, got.r23_d_ca);
                end
            end
        end
        outstanding = pending_xforms.size();
    end

endmodule

>>> tb/tb_mdh_link_transform_unit.sv
`timescale 1ns / 1ps

// Streams joint parameter requests into the link transform unit with random
// gaps on both sides; the checker beside the unit predicts and compares.
module tb_mdh_link_transform_unit;

    localparam int PIPE_LAT    = ((mdh_pkg::CORDIC_STAGES > mdh_pkg::ATAN_LEN) ?
                                  mdh_pkg::ATAN_LEN : mdh_pkg::CORDIC_STAGES) + 4;
    localparam int RANDOM_REQS = 1850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 1000;   // receiver cycle where the long hold-off starts
    localparam int HOLD_LEN    = 300;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;

    int mismatches;
    int outstanding;
    int cycles;
    int send_idle_pct;

    mdh_link_transform_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mdh_link_xform_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Offer one request, maybe after a one-cycle gap, and hold it until taken.
    // valid stays high between back-to-back requests.
    task automatic send_request(input logic signed [31:0] len,
                                input logic signed [15:0] twist,
                                input logic signed [31:0] offs,
                                input logic signed [15:0] angle);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {angle, offs, twist, len};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly in +-pi, some raw 16-bit patterns, some quadrant edges.
    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] a;
        case ($urandom_range(9))
            0: a = 16'($urandom);
            1: begin
                case ($urandom_range(6))
                    0:       a = 16'sd0;
                    1:       a = 16'sd12867;
                    2:       a = 16'sd12868;
                    3:       a = -16'sd12867;
                    4:       a = -16'sd12868;
                    5:       a = 16'sd25736;
                    default: a = -16'sd25736;
                endcase
            end
            default: a = 16'($urandom_range(51472) - 25736);
        endcase
        return a;
    endfunction

    function automatic logic signed [31:0] pick_length();
        logic signed [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'sh8000_0000;
            1:       v = 32'sh7fff_ffff;
            2, 3:    v = 32'($urandom_range(131071) - 65536);
            default: v = 32'($urandom);
        endcase
        return v;
    endfunction

    // Receiver: random stalls, a quiet stretch, and one long hold-off that
    // backs the pipe up into the input.
    initial begin : receiver
        int rx_cycle;
        int rx_idle_pct;
        m_tready <= 1'b0;
        rx_cycle = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_cycle == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                rx_cycle += HOLD_LEN;
            end else begin
                rx_idle_pct = (rx_cycle >= 300 && rx_cycle < 800) ? 0 : 8;
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
                @(posedge aclk);
                rx_cycle++;
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        send_idle_pct = 8;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // field extremes and quadrant edges
        send_request(32'sd0, 16'sd0, 32'sd0, 16'sd0);
        send_request(32'sh7fff_ffff, 16'sd25736, 32'sh7fff_ffff, 16'sd25736);
        send_request(32'sh8000_0000, -16'sd25736, 32'sh8000_0000, -16'sd25736);
        send_request(32'sh7fff_ffff, -16'sd12868, 32'sh7fff_ffff, -16'sd12868);
        send_request(32'sd65536, 16'sd12867, 32'sd65536, 16'sd12867);
        send_request(-32'sd65536, -16'sd12867, -32'sd65536, -16'sd12868);
        // most negative offset: -d*sa overflows at alpha = pi/2, d*ca at alpha = pi
        send_request(32'sh8000_0000, 16'sd12868, 32'sh8000_0000, 16'sd0);
        send_request(32'sh8000_0000, 16'sd25736, 32'sh8000_0000, 16'sd12868);
        send_request(32'sd1, -16'sd12868, 32'sh8000_0000, 16'sd25736);
        // raw angle patterns, some past +-pi, then +-1 LSB, pi/4 and +-3pi/4 angles
        send_request(32'sd0, 16'sh7fff, 32'sd0, 16'sh8000);
        send_request(32'sd0, 16'sh8000, 32'sh7fff_ffff, 16'sh7fff);
        send_request(32'sh5555_5555, 16'sh5555, 32'shaaaa_aaaa, 16'shaaaa);
        send_request(32'sd1, 16'sd1, -32'sd1, -16'sd1);
        send_request(-32'sd1, -16'sd1, 32'sd1, 16'sd1);
        send_request(32'sd65536, 16'sd6434, 32'sd65536, 16'sd6434);
        send_request(32'shffff, -16'sd19302, 32'sh0001_0000, 16'sd19302);

        for (int k = 0; k < RANDOM_REQS; k++) begin
            send_idle_pct = (k >= 400 && k < 800) ? 0 : 8;
            send_request(pick_length(), pick_angle(), pick_length(), pick_angle());
        end
        s_tvalid <= 1'b0;

        // drain, then give the pipe time to show any stray result
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (2 * PIPE_LAT) @(posedge aclk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/mdh_pkg.sv
sv/mdh_cordic.sv
sv/mdh_link_transform_unit.sv
sv/mdh_checker.sv
tb/mdh_link_xform_checker.sv
tb/tb_mdh_link_transform_unit.sv
